FILE: rtl/ffst_pkg.sv
// ----------------------------------------------------------------------------
// ffst_pkg: shared types and constants of the first-free slot table
// Request and result payload structs, action codes, register map and the
// slot limit clamp used by the table sequencer.
// ----------------------------------------------------------------------------
package ffst_pkg;

	localparam int SLOTS   = 16;
	localparam int ID_BITS = 16;

	// Field widths of the request and result items.
	localparam int ITEM_W  = 16;
	localparam int IDX_W   = 4;
	localparam int CNT_W   = 5;
	localparam int LIMIT_W = 5;

	// Configuration port.
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [PADDR_W-3:0] REG_SLOT_LIMIT = 1'b0;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET    = 5'd16;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_MOVE   = 2'd2,
		ACT_READ   = 2'd3
	} action_t;

	typedef struct packed {
		action_t           action;
		logic [ITEM_W-1:0] item_id;
		logic [IDX_W-1:0]  slot_index;
		logic [IDX_W-1:0]  to_index;
	} req_t;

	typedef struct packed {
		logic              ok;
		logic [ITEM_W-1:0] item_out;
		logic [IDX_W-1:0]  added_slot;
		logic              changed;
		logic [CNT_W-1:0]  item_count;
	} rsp_t;

	// The register accepts any 5-bit value; the table uses it clamped into 1..SLOTS.
	function automatic logic [LIMIT_W-1:0] eff_limit(input logic [LIMIT_W-1:0] value);
		logic [LIMIT_W-1:0] lim;
		lim = value;
		if (value == '0) begin
			lim = LIMIT_W'(1);
		end else if (value > LIMIT_W'(SLOTS)) begin
			lim = LIMIT_W'(SLOTS);
		end
		return lim;
	endfunction

endpackage

FILE: rtl/first_free_slot_table_unit.sv
// ----------------------------------------------------------------------------
// first_free_slot_table_unit: first-fit slot table with add, remove, move, read
// A small sequencer walks a 16-entry id memory one slot per cycle, with one
// occupancy bit per slot, and returns one result item for every request.
// ----------------------------------------------------------------------------
// Each request gives one result item, set by a sequencer around one id memory
// with a registered read and one slot counter. A request that fails its
// checks goes straight to the finish state; read and remove pass through
// RD_A and GET, and a move through RD_A, RD_B, WR_A and WR_B (two reads, two
// writes). An add searches for the first free slot, stepping through the
// occupancy bits one slot per cycle. The block returns to idle when a result
// is loaded and takes the next request from there. The result sits in an output
// register, so the next request is taken while it waits. Reset empties the
// table at once through the occupancy bits. After a write of slot_limit the
// block passes through idle into a recount that steps through all the slots
// to empty those at or above the new limit and to recount the table; no
// request is taken in that time.
module first_free_slot_table_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             req_valid,
	output logic                             req_ready,
	input  ffst_pkg::req_t                   req,
	output logic                             rsp_valid,
	input  logic                             rsp_ready,
	output ffst_pkg::rsp_t                   rsp,
	input  logic                             psel,
	input  logic                             penable,
	input  logic                             pwrite,
	input  logic [ffst_pkg::PADDR_W-1:0]     paddr,
	input  logic [ffst_pkg::PDATA_W-1:0]     pwdata,
	output logic [ffst_pkg::PDATA_W-1:0]     prdata,
	output logic                             pready
);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SCAN,
		ST_RD_A,
		ST_RD_B,
		ST_GET,
		ST_WR_A,
		ST_WR_B,
		ST_RECOUNT,
		ST_FINISH
	} state_t;

	state_t                             state_q;
	logic [ffst_pkg::SLOTS-1:0]         occ_q;
	logic [ffst_pkg::CNT_W-1:0]         count_q;
	logic [ffst_pkg::LIMIT_W-1:0]       slot_limit_q;
	logic                               recount_pend_q;
	logic [ffst_pkg::IDX_W-1:0]         scan_q;
	ffst_pkg::action_t                  act_q;
	logic [ffst_pkg::ID_BITS-1:0]       id_q;
	logic [ffst_pkg::IDX_W-1:0]         a_q;
	logic [ffst_pkg::IDX_W-1:0]         b_q;
	logic [ffst_pkg::LIMIT_W-1:0]       lim_q;
	logic                               occ_a_q;
	logic                               occ_b_q;
	logic [ffst_pkg::ID_BITS-1:0]       tmp_a_q;
	ffst_pkg::rsp_t                     res_q;
	ffst_pkg::rsp_t                     rsp_q;
	logic                               rsp_valid_q;

	logic [ffst_pkg::ID_BITS-1:0]       mem [ffst_pkg::SLOTS];
	logic [ffst_pkg::ID_BITS-1:0]       rd_data_q;
	logic [ffst_pkg::IDX_W-1:0]         rd_addr;
	logic                               mem_we;
	logic [ffst_pkg::IDX_W-1:0]         mem_waddr;
	logic [ffst_pkg::ID_BITS-1:0]       mem_wdata;

	logic                               cfg_wr;
	logic                               cfg_hit;
	logic [ffst_pkg::LIMIT_W-1:0]       cur_lim;
	logic                               req_fire;
	logic [ffst_pkg::ID_BITS-1:0]       req_id;
	logic                               req_va;
	logic                               req_vb;
	logic                               fin_take;
	ffst_pkg::rsp_t                     fin_rsp;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_hit = (paddr[ffst_pkg::PADDR_W-1:2] == ffst_pkg::REG_SLOT_LIMIT);
	assign prdata  = cfg_hit ? ffst_pkg::PDATA_W'(slot_limit_q) : '0;
	assign cur_lim = ffst_pkg::eff_limit(slot_limit_q);

	assign req_ready = (state_q == ST_IDLE) && !recount_pend_q && !cfg_wr;
	assign req_fire  = req_valid && req_ready;
	assign req_id    = req.item_id[ffst_pkg::ID_BITS-1:0];
	assign req_va    = {1'b0, req.slot_index} < cur_lim;
	assign req_vb    = {1'b0, req.to_index} < cur_lim;

	assign fin_take  = (state_q == ST_FINISH) && (!rsp_valid_q || rsp_ready);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		fin_rsp            = res_q;
		fin_rsp.item_count = count_q;
	end

	// Memory port control: the read address is b only while fetching the
	// destination of a move.
	always_comb begin
		rd_addr   = (state_q == ST_RD_B) ? b_q : a_q;
		mem_we    = 1'b0;
		mem_waddr = a_q;
		mem_wdata = rd_data_q;
		unique case (state_q)
			ST_SCAN: begin
				mem_we    = !occ_q[scan_q];
				mem_waddr = scan_q;
				mem_wdata = id_q;
			end
			ST_WR_A: begin
				mem_we    = 1'b1;
				mem_waddr = a_q;
				mem_wdata = rd_data_q;
			end
			ST_WR_B: begin
				mem_we    = 1'b1;
				mem_waddr = b_q;
				mem_wdata = tmp_a_q;
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		rd_data_q <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			occ_q          <= '0;
			count_q        <= '0;
			slot_limit_q   <= ffst_pkg::LIMIT_RESET;
			recount_pend_q <= 1'b0;
			scan_q         <= '0;
			act_q          <= ffst_pkg::ACT_ADD;
			id_q           <= '0;
			a_q            <= '0;
			b_q            <= '0;
			lim_q          <= '0;
			occ_a_q        <= 1'b0;
			occ_b_q        <= 1'b0;
			tmp_a_q        <= '0;
			res_q          <= '0;
			rsp_q          <= '0;
			rsp_valid_q    <= 1'b0;
		end else begin
			if (fin_take) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (recount_pend_q) begin
						scan_q         <= '0;
						count_q        <= '0;
						state_q        <= ST_RECOUNT;
					end else if (req_fire) begin
						act_q   <= req.action;
						id_q    <= req_id;
						a_q     <= req.slot_index;
						b_q     <= req.to_index;
						lim_q   <= cur_lim;
						occ_a_q <= occ_q[req.slot_index];
						occ_b_q <= occ_q[req.to_index];
						res_q   <= '0;
						unique case (req.action)
							ffst_pkg::ACT_ADD: begin
								if (req_id != '0 && count_q < cur_lim) begin
									scan_q  <= '0;
									state_q <= ST_SCAN;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							ffst_pkg::ACT_REMOVE: begin
								if (req_va && occ_q[req.slot_index]) begin
									state_q <= ST_RD_A;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							ffst_pkg::ACT_MOVE: begin
								if (req_va && req_vb) begin
									state_q <= ST_RD_A;
								end else begin
									state_q <= ST_FINISH;
								end
							end
							ffst_pkg::ACT_READ: begin
								if (req_va) begin
									state_q <= ST_RD_A;
								end else begin
									state_q <= ST_FINISH;
								end
							end
						endcase
					end
				end

				ST_SCAN: begin
					if (!occ_q[scan_q]) begin
						occ_q[scan_q]    <= 1'b1;
						count_q          <= count_q + 1'b1;
						res_q.ok         <= 1'b1;
						res_q.changed    <= 1'b1;
						res_q.added_slot <= scan_q;
						state_q          <= ST_FINISH;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end

				ST_RD_A: begin
					state_q <= (act_q == ffst_pkg::ACT_MOVE) ? ST_RD_B : ST_GET;
				end

				ST_RD_B: begin
					tmp_a_q <= rd_data_q;
					state_q <= ST_WR_A;
				end

				ST_GET: begin
					// An empty slot may hold a stale id in memory; it reads as zero.
					res_q.ok       <= 1'b1;
					res_q.item_out <= occ_a_q ? ffst_pkg::ITEM_W'(rd_data_q) : '0;
					if (act_q == ffst_pkg::ACT_REMOVE) begin
						occ_q[a_q]    <= 1'b0;
						count_q       <= count_q - 1'b1;
						res_q.changed <= 1'b1;
					end
					state_q <= ST_FINISH;
				end

				ST_WR_A: begin
					occ_q[a_q] <= occ_b_q;
					state_q    <= ST_WR_B;
				end

				ST_WR_B: begin
					occ_q[b_q]    <= occ_a_q;
					res_q.ok      <= 1'b1;
					res_q.changed <= 1'b1;
					state_q       <= ST_FINISH;
				end

				ST_RECOUNT: begin
					// Slots at or above the limit are emptied, the rest are counted.
					if ({1'b0, scan_q} >= cur_lim) begin
						occ_q[scan_q] <= 1'b0;
					end else begin
						count_q <= count_q + ffst_pkg::CNT_W'(occ_q[scan_q]);
					end
					scan_q <= scan_q + 1'b1;
					if (scan_q == ffst_pkg::IDX_W'(ffst_pkg::SLOTS - 1)) begin
						state_q <= ST_IDLE;
					end
				end

				ST_FINISH: begin
					if (fin_take) begin
						rsp_q   <= fin_rsp;
						state_q <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			if (cfg_wr && cfg_hit) begin
				slot_limit_q   <= pwdata[ffst_pkg::LIMIT_W-1:0];
				recount_pend_q <= 1'b1;
			end else if (state_q == ST_IDLE) begin
				recount_pend_q <= 1'b0;
			end
		end
	end

	// The running count matches the occupancy bits whenever the table is at rest.
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !recount_pend_q) |-> (count_q == $countones(occ_q)))
		else $error("occupied count differs from occupancy bits");

	// No slot at or above the limit is occupied once a resize has been applied.
	a_no_occ_above_limit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE && !recount_pend_q) |-> ((occ_q >> cur_lim) == '0))
		else $error("slot above the limit is occupied");

	// The free slot search always ends below the limit it started with.
	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> ({1'b0, scan_q} < lim_q))
		else $error("free slot search ran past the limit");

	// An accepted request holds off the next one while it is worked on.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> !req_ready)
		else $error("request taken while the sequencer is busy");

endmodule

FILE: verif/tb_first_free_slot_table_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_first_free_slot_table_unit: self-checking bench for the first-fit slot table
// A table of directed requests and limit writes is followed by biased random
// requests under several slot limits and idle patterns. Every accepted request
// is run through a shadow copy of the table, and every result item is compared
// field by field with the oldest expected result.
// ----------------------------------------------------------------------------
module tb_first_free_slot_table_unit;

	localparam logic [ffst_pkg::PADDR_W-1:0] LIMIT_ADDR = {ffst_pkg::REG_SLOT_LIMIT, 2'b00};
	localparam int CHUNKS = 14;
	localparam int CHUNK_ITEMS = 125;

	typedef struct packed {
		bit                           is_limit;
		logic [ffst_pkg::LIMIT_W-1:0] limit_value;
		ffst_pkg::req_t               rq;
		bit                           typed_valid;
		ffst_pkg::rsp_t               typed;
	} dir_row_t;

	logic                         clk;
	logic                         arst_n;
	logic                         req_valid;
	logic                         req_ready;
	ffst_pkg::req_t               req;
	logic                         rsp_valid;
	logic                         rsp_ready;
	ffst_pkg::rsp_t               rsp;
	logic                         psel;
	logic                         penable;
	logic                         pwrite;
	logic [ffst_pkg::PADDR_W-1:0] paddr;
	logic [ffst_pkg::PDATA_W-1:0] pwdata;
	logic [ffst_pkg::PDATA_W-1:0] prdata;
	logic                         pready;

	// Shadow copy of the table contents and the limit register.
	logic [ffst_pkg::ITEM_W-1:0]  shadow_ids [ffst_pkg::SLOTS];
	int                           shadow_count;
	logic [ffst_pkg::LIMIT_W-1:0] shadow_limit;

	ffst_pkg::rsp_t expected_results [$];
	int   failures = 0;
	int   req_idle_pct = 0;
	int   rsp_idle_pct = 0;
	int   rsp_hold_left = 0;

	first_free_slot_table_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int active_slots();
		if (shadow_limit == '0) begin
			return 1;
		end
		if (shadow_limit > ffst_pkg::SLOTS) begin
			return ffst_pkg::SLOTS;
		end
		return int'(shadow_limit);
	endfunction

	// Applies one request to the shadow table and returns the result it should give.
	function automatic ffst_pkg::rsp_t apply_request(input ffst_pkg::req_t r);
		ffst_pkg::rsp_t res;
		int lim;
		int i;
		bit placed;
		logic [ffst_pkg::ITEM_W-1:0] held;
		res = '0;
		placed = 1'b0;
		lim = active_slots();
		case (r.action)
			ffst_pkg::ACT_ADD: begin
				if (r.item_id != '0 && shadow_count < lim) begin
					for (i = 0; i < lim; i++) begin
						if (!placed && shadow_ids[i] == '0) begin
							shadow_ids[i] = r.item_id;
							shadow_count++;
							placed = 1'b1;
							res.ok = 1'b1;
							res.changed = 1'b1;
							res.added_slot = ffst_pkg::IDX_W'(i);
						end
					end
				end
			end
			ffst_pkg::ACT_REMOVE: begin
				if (r.slot_index < lim && shadow_ids[r.slot_index] != '0) begin
					res.item_out = shadow_ids[r.slot_index];
					shadow_ids[r.slot_index] = '0;
					shadow_count--;
					res.ok = 1'b1;
					res.changed = 1'b1;
				end
			end
			ffst_pkg::ACT_MOVE: begin
				// A move onto the same slot still counts as a change.
				if (r.slot_index < lim && r.to_index < lim) begin
					held = shadow_ids[r.slot_index];
					shadow_ids[r.slot_index] = shadow_ids[r.to_index];
					shadow_ids[r.to_index] = held;
					res.ok = 1'b1;
					res.changed = 1'b1;
				end
			end
			default: begin
				if (r.slot_index < lim) begin
					res.item_out = shadow_ids[r.slot_index];
					res.ok = 1'b1;
				end
			end
		endcase
		res.item_count = ffst_pkg::CNT_W'(shadow_count);
		return res;
	endfunction

	function automatic ffst_pkg::req_t random_request(input int add_pct);
		ffst_pkg::req_t r;
		int lim;
		int pick;
		int rest;
		lim = active_slots();
		rest = 100 - add_pct;
		pick = $urandom_range(99);
		if (pick < add_pct) begin
			r.action = ffst_pkg::ACT_ADD;
		end else if (pick < add_pct + rest / 2) begin
			r.action = ffst_pkg::ACT_REMOVE;
		end else if (pick < add_pct + (3 * rest) / 4) begin
			r.action = ffst_pkg::ACT_MOVE;
		end else begin
			r.action = ffst_pkg::ACT_READ;
		end
		case ($urandom_range(19))
			0: r.item_id = '0;
			1: r.item_id = '1;
			default: r.item_id = ffst_pkg::ITEM_W'($urandom);
		endcase
		// Most indices land inside the active part of the table.
		if ($urandom_range(99) < 80) begin
			r.slot_index = ffst_pkg::IDX_W'($urandom_range(lim - 1));
		end else begin
			r.slot_index = ffst_pkg::IDX_W'($urandom_range(ffst_pkg::SLOTS - 1));
		end
		if ($urandom_range(99) < 80) begin
			r.to_index = ffst_pkg::IDX_W'($urandom_range(lim - 1));
		end else begin
			r.to_index = ffst_pkg::IDX_W'($urandom_range(ffst_pkg::SLOTS - 1));
		end
		return r;
	endfunction

	function automatic dir_row_t row_req(input ffst_pkg::action_t a,
			input logic [ffst_pkg::ITEM_W-1:0] id, input logic [ffst_pkg::IDX_W-1:0] si,
			input logic [ffst_pkg::IDX_W-1:0] ti);
		dir_row_t row;
		row = '0;
		row.rq.action = a;
		row.rq.item_id = id;
		row.rq.slot_index = si;
		row.rq.to_index = ti;
		return row;
	endfunction

	function automatic dir_row_t row_chk(input ffst_pkg::action_t a,
			input logic [ffst_pkg::ITEM_W-1:0] id, input logic [ffst_pkg::IDX_W-1:0] si,
			input logic [ffst_pkg::IDX_W-1:0] ti, input logic ok,
			input logic [ffst_pkg::ITEM_W-1:0] io, input logic [ffst_pkg::IDX_W-1:0] slot,
			input logic chg, input logic [ffst_pkg::CNT_W-1:0] cnt);
		dir_row_t row;
		row = row_req(a, id, si, ti);
		row.typed_valid = 1'b1;
		row.typed.ok = ok;
		row.typed.item_out = io;
		row.typed.added_slot = slot;
		row.typed.changed = chg;
		row.typed.item_count = cnt;
		return row;
	endfunction

	function automatic dir_row_t row_limit(input logic [ffst_pkg::LIMIT_W-1:0] value);
		dir_row_t row;
		row = '0;
		row.is_limit = 1'b1;
		row.limit_value = value;
		return row;
	endfunction

	// Called right after an accepting edge; leaves at the edge that takes the next item.
	task automatic send_request(input ffst_pkg::req_t r, input bit typed_valid,
			input ffst_pkg::rsp_t typed);
		ffst_pkg::rsp_t predicted;
		if ($urandom_range(99) < req_idle_pct) begin
			req_valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < req_idle_pct);
		end
		req_valid <= 1'b1;
		req <= r;
		do @(posedge clk); while (!req_ready);
		predicted = apply_request(r);
		expected_results.push_back(typed_valid ? typed : predicted);
	endtask

	task automatic drain_results();
		req_valid <= 1'b0;
		while (expected_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic write_slot_limit(input logic [ffst_pkg::LIMIT_W-1:0] value);
		int lim;
		int i;
		drain_results();
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= LIMIT_ADDR;
		pwdata <= ffst_pkg::PDATA_W'(value);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		// Slots beyond the new limit are dropped and the count rebuilt.
		shadow_limit = value;
		lim = active_slots();
		shadow_count = 0;
		for (i = 0; i < ffst_pkg::SLOTS; i++) begin
			if (i >= lim) begin
				shadow_ids[i] = '0;
			end
			if (shadow_ids[i] != '0) begin
				shadow_count++;
			end
		end
	endtask

	initial begin : receiver
		rsp_ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_hold_left > 0) begin
				rsp_hold_left = rsp_hold_left - 1;
				rsp_ready <= 1'b0;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : result_check
		ffst_pkg::rsp_t want;
		if (arst_n && rsp_valid && rsp_ready) begin
			if (expected_results.size() == 0) begin
				failures++;
				$display("%0t: unexpected result ok=%0b item=%h slot=%0d changed=%0b count=%0d",
					$time, rsp.ok, rsp.item_out, rsp.added_slot, rsp.changed, rsp.item_count);
			end else begin
				want = expected_results.pop_front();
				if (rsp.ok !== want.ok || rsp.item_out !== want.item_out ||
						rsp.added_slot !== want.added_slot || rsp.changed !== want.changed ||
						rsp.item_count !== want.item_count) begin
					failures++;
					$display("%0t: mismatch expected ok=%0b item=%h slot=%0d changed=%0b count=%0d",
						$time, want.ok, want.item_out, want.added_slot, want.changed,
						want.item_count);
					$display("%0t:          actual   ok=%0b item=%h slot=%0d changed=%0b count=%0d",
						$time, rsp.ok, rsp.item_out, rsp.added_slot, rsp.changed,
						rsp.item_count);
				end
			end
		end
	end

	initial begin : stimulus
		dir_row_t dir_rows [$];
		int limit_plan [CHUNKS];
		int chunk;
		int n;
		int i;
		logic [ffst_pkg::LIMIT_W-1:0] next_limit;
		arst_n <= 1'b0;
		req_valid <= 1'b0;
		req <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		for (i = 0; i < ffst_pkg::SLOTS; i++) begin
			shadow_ids[i] = '0;
		end
		shadow_count = 0;
		shadow_limit = ffst_pkg::LIMIT_RESET;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Empty table, failing requests, first-fit order, moves and limit corners.
		dir_rows.push_back(row_chk(ffst_pkg::ACT_READ, 16'h0000, 4'd0, 4'd0,
			1'b1, 16'h0000, 4'd0, 1'b0, 5'd0));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_READ, 16'hffff, 4'd15, 4'd15,
			1'b1, 16'h0000, 4'd0, 1'b0, 5'd0));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_REMOVE, 16'h0000, 4'd15, 4'd0,
			1'b0, 16'h0000, 4'd0, 1'b0, 5'd0));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_ADD, 16'h0000, 4'd0, 4'd0,
			1'b0, 16'h0000, 4'd0, 1'b0, 5'd0));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_ADD, 16'hffff, 4'd15, 4'd15,
			1'b1, 16'h0000, 4'd0, 1'b1, 5'd1));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_ADD, 16'h0001, 4'd0, 4'd0,
			1'b1, 16'h0000, 4'd1, 1'b1, 5'd2));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_ADD, 16'h8000, 4'd0, 4'd0,
			1'b1, 16'h0000, 4'd2, 1'b1, 5'd3));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_READ, 16'h0000, 4'd0, 4'd0,
			1'b1, 16'hffff, 4'd0, 1'b0, 5'd3));
		dir_rows.push_back(row_req(ffst_pkg::ACT_MOVE, 16'h0000, 4'd0, 4'd15));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_MOVE, 16'h0000, 4'd1, 4'd1,
			1'b1, 16'h0000, 4'd0, 1'b1, 5'd3));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_REMOVE, 16'h0000, 4'd1, 4'd0,
			1'b1, 16'h0001, 4'd0, 1'b1, 5'd2));
		dir_rows.push_back(row_req(ffst_pkg::ACT_ADD, 16'haaaa, 4'd0, 4'd0));
		dir_rows.push_back(row_req(ffst_pkg::ACT_READ, 16'h0000, 4'd15, 4'd0));
		dir_rows.push_back(row_limit(5'd0));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_ADD, 16'h1234, 4'd0, 4'd0,
			1'b0, 16'h0000, 4'd0, 1'b0, 5'd1));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_READ, 16'h0000, 4'd1, 4'd0,
			1'b0, 16'h0000, 4'd0, 1'b0, 5'd1));
		dir_rows.push_back(row_chk(ffst_pkg::ACT_MOVE, 16'h0000, 4'd0, 4'd1,
			1'b0, 16'h0000, 4'd0, 1'b0, 5'd1));
		dir_rows.push_back(row_req(ffst_pkg::ACT_REMOVE, 16'h0000, 4'd0, 4'd0));
		dir_rows.push_back(row_limit(5'd31));
		dir_rows.push_back(row_req(ffst_pkg::ACT_ADD, 16'h5555, 4'd0, 4'd0));
		dir_rows.push_back(row_req(ffst_pkg::ACT_MOVE, 16'h0000, 4'd15, 4'd0));
		dir_rows.push_back(row_req(ffst_pkg::ACT_REMOVE, 16'h0000, 4'd15, 4'd0));
		dir_rows.push_back(row_limit(5'd17));
		dir_rows.push_back(row_req(ffst_pkg::ACT_READ, 16'h0000, 4'd15, 4'd0));
		dir_rows.push_back(row_limit(5'd16));

		foreach (dir_rows[k]) begin
			if (dir_rows[k].is_limit) begin
				write_slot_limit(dir_rows[k].limit_value);
			end else begin
				send_request(dir_rows[k].rq, dir_rows[k].typed_valid, dir_rows[k].typed);
			end
		end

		// A negative entry picks a random limit, out-of-range values included.
		limit_plan = '{16, 1, 31, 0, 5, 17, 16, 2, -1, 16, 8, -1, 3, 16};
		for (chunk = 0; chunk < CHUNKS; chunk++) begin
			if (limit_plan[chunk] < 0) begin
				next_limit = ffst_pkg::LIMIT_W'($urandom_range(31));
			end else begin
				next_limit = ffst_pkg::LIMIT_W'(limit_plan[chunk]);
			end
			write_slot_limit(next_limit);
			req_idle_pct = (chunk < 5) ? 20 : (chunk < 10) ? 88 : 0;
			rsp_idle_pct = (chunk < 5) ? 88 : (chunk < 10) ? 20 : 0;
			for (n = 0; n < CHUNK_ITEMS; n++) begin
				// Hold the result side off while items keep coming, so the input backs up.
				if (chunk == 12 && n == 10) begin
					rsp_hold_left = 300;
				end
				send_request(random_request((chunk % 2 == 0) ? 60 : 30), 1'b0, '0);
			end
		end

		drain_results();
		repeat (40) @(posedge clk);
		if (failures == 0) begin
			$display("tb_first_free_slot_table_unit: PASS");
		end else begin
			$display("tb_first_free_slot_table_unit: FAIL");
		end
		$finish;
	end

	initial begin : watchdog
		#20_000_000;
		$display("tb_first_free_slot_table_unit: FAIL");
		$finish;
	end

endmodule
